// ===== hw/rtl/pcpt_pkg.sv =====
// ----------------------------------------------------------------------------
// pcpt_pkg
// Shared constants, types and helper functions of the pose compose and
// point transform block.
// ----------------------------------------------------------------------------
package pcpt_pkg;

  localparam int ROT_FRAC_BITS        = 30;
  localparam int CORDIC_STEPS         = 24;
  localparam int ANGLE_UNITS_PER_TURN = 46080;
  localparam int CORDIC_GAIN          = 652032874;
  localparam int CORDIC_RSH           = 30 - ROT_FRAC_BITS;
  localparam int CORDIC_W             = 34;
  localparam int CNT_W                = 6;
  localparam int ACC_W                = 67;
  localparam int SUM_W                = 38;

  // 46080 = 45 * 1024, so (m * 2^32 + 23040) / 46080 splits into
  // ANG_MUL * m + (ANG_REM * m + ANG_RND) / 45, the last term by a
  // reciprocal multiply that is exact for operands below 2^22
  localparam int ANG_MUL      = 93206;
  localparam int ANG_REM      = 34;
  localparam int ANG_RND      = 22;
  localparam int ANG_RECIP    = 5965233;
  localparam int ANG_RECIP_SH = 28;

  localparam logic [1:0] OP_FIXED = 2'd0;
  localparam logic [1:0] OP_BODY  = 2'd1;
  localparam logic [1:0] OP_POINT = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_PREP,
    ST_CORDIC,
    ST_DOT,
    ST_COMMIT
  } eng_state_t;

  // body is set for body-frame compose and for points: both multiply the
  // pose rows by a vector on the right
  typedef struct packed {
    logic               is_point;
    logic               body;
    logic [1:0]         axis;
    logic signed [16:0] angle;
    logic signed [31:0] v0;
    logic signed [31:0] v1;
    logic signed [31:0] v2;
  } item_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } point_t;

  function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(64'sh7fffffff);
    lo = -SUM_W'(64'sh80000000);
    if (v > hi) return 32'sh7fffffff;
    else if (v < lo) return 32'sh80000000;
    else return v[31:0];
  endfunction

  // CORDIC output to rotation format, rounded half up, saturated
  function automatic logic signed [31:0] cordic_out(input logic signed [CORDIC_W-1:0] v);
    logic signed [CORDIC_W:0] t;
    logic signed [CORDIC_W:0] half;
    half = (CORDIC_W+1)'(1) <<< (CORDIC_RSH > 0 ? CORDIC_RSH - 1 : 0);
    if (CORDIC_RSH == 0) t = (CORDIC_W+1)'(v);
    else t = ((CORDIC_W+1)'(v) + half) >>> CORDIC_RSH;
    return sat32(SUM_W'(t));
  endfunction

  // arctangent of 2^-k, one full turn is 2^32
  function automatic logic [31:0] atan_at(input logic [4:0] k);
    case (k)
      5'd0:  return 32'h20000000;
      5'd1:  return 32'h12E4051E;
      5'd2:  return 32'h09FB385B;
      5'd3:  return 32'h051111D4;
      5'd4:  return 32'h028B0D43;
      5'd5:  return 32'h0145D7E1;
      5'd6:  return 32'h00A2F61E;
      5'd7:  return 32'h00517C55;
      5'd8:  return 32'h0028BE53;
      5'd9:  return 32'h00145F2F;
      5'd10: return 32'h000A2F98;
      5'd11: return 32'h000517CC;
      5'd12: return 32'h00028BE6;
      5'd13: return 32'h000145F3;
      5'd14: return 32'h0000A2FA;
      5'd15: return 32'h0000517D;
      5'd16: return 32'h000028BE;
      5'd17: return 32'h0000145F;
      5'd18: return 32'h00000A30;
      5'd19: return 32'h00000518;
      5'd20: return 32'h0000028C;
      5'd21: return 32'h00000146;
      5'd22: return 32'h000000A3;
      5'd23: return 32'h00000051;
      5'd24: return 32'h00000029;
      5'd25: return 32'h00000014;
      5'd26: return 32'h0000000A;
      5'd27: return 32'h00000005;
      5'd28: return 32'h00000003;
      5'd29: return 32'h00000001;
      5'd30: return 32'h00000001;
      default: return 32'h00000000;
    endcase
  endfunction

endpackage

// ===== hw/rtl/pcpt_front.sv =====
// ----------------------------------------------------------------------------
// pcpt_front
// Accepts requests, drops the unused op code, selects the operand vector and
// holds up to two classified items for the engine.
// ----------------------------------------------------------------------------
module pcpt_front import pcpt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [1:0]         in_op,
  input  logic [1:0]         in_axis,
  input  logic signed [16:0] in_angle,
  input  logic signed [31:0] in_shift_x,
  input  logic signed [31:0] in_shift_y,
  input  logic signed [31:0] in_shift_z,
  input  logic signed [31:0] in_point_x,
  input  logic signed [31:0] in_point_y,
  input  logic signed [31:0] in_point_z,
  input  logic               q_pop,
  output logic               q_empty,
  output item_t              q_item
);

  item_t      mem_r [2];
  logic [1:0] cnt_r;
  logic       wp_r;
  logic       rp_r;
  logic       keep;
  item_t      itm;

  assign in_full = (cnt_r == 2'd2);
  assign q_empty = (cnt_r == 2'd0);
  assign q_item  = mem_r[rp_r];
  assign keep    = in_push && !in_full && (in_op != OP_NONE);

  always_comb begin
    itm.is_point = (in_op == OP_POINT);
    itm.body     = (in_op != OP_FIXED);
    itm.axis     = in_axis;
    itm.angle    = in_angle;
    itm.v0       = itm.is_point ? in_point_x : in_shift_x;
    itm.v1       = itm.is_point ? in_point_y : in_shift_y;
    itm.v2       = itm.is_point ? in_point_z : in_shift_z;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_r + 2'(keep) - 2'(q_pop);
      if (keep) wp_r <= !wp_r;
      if (q_pop) rp_r <= !rp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (keep) mem_r[wp_r] <= itm;
  end

endmodule

// ===== hw/rtl/pcpt_engine.sv =====
// ----------------------------------------------------------------------------
// pcpt_engine
// Back end: angle scaling by reciprocal multiply, CORDIC, and a shared
// multiplier that forms every 3-term dot product of a compose or a point
// transform.
// ----------------------------------------------------------------------------
module pcpt_engine import pcpt_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   q_empty,
  input  item_t  q_item,
  output logic   q_pop,
  input  logic   oq_full,
  output logic   oq_push,
  output point_t oq_data
);

  localparam logic [2:0] PH_FIN = 3'd4;
  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) <<< (ROT_FRAC_BITS - 1);
  localparam logic signed [31:0] ONE = 32'(64'sd1 <<< ROT_FRAC_BITS);

  eng_state_t st_r, st_nxt;
  item_t      it_r;

  logic [16:0]         mag_r;
  logic [21:0]         frac_r;
  logic [33:0]         base_r;
  logic [44:0]         recp_r;
  logic [31:0]         quo_r;
  logic [CNT_W-1:0]    cnt_r;

  logic signed [CORDIC_W-1:0] cx_r, cy_r, cz_r;
  logic                       flip_r;
  logic signed [31:0]         s_r, c_r;

  logic [1:0]  r_r, k_r;
  logic [2:0]  ph_r;
  logic signed [63:0]    prod_r;
  logic signed [ACC_W-1:0] acc_r;

  logic signed [31:0] rot_r [9];
  logic signed [31:0] tr_r [3];
  logic signed [31:0] nrot_r [9];
  logic signed [31:0] ntr_r [3];
  logic signed [31:0] ob_r [2];

  // combinational
  logic               last_dot;
  logic [16:0]        mag;
  logic [31:0]        ba;
  logic               flp;
  logic [31:0]        ba2;
  logic [4:0]         kk;
  logic signed [CORDIC_W-1:0] dx, dy, atv;
  logic signed [CORDIC_W-1:0] fx, fy;
  logic signed [31:0] w [9];
  logic [1:0]         j;
  logic [1:0]         tix;
  logic [3:0]         ridx, widx, sidx;
  logic signed [31:0] vec_t, vec_j, tr_t, a_op, b_op, add_v;
  logic signed [63:0] prod_nxt;
  logic signed [ACC_W-1:0] rnd;
  logic signed [SUM_W-1:0] rsum;
  logic signed [31:0] res;

  assign last_dot = (r_r == 2'd2) && (k_r == 2'd3);

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= ST_IDLE;
    else st_r <= st_nxt;
  end

  always_comb begin
    st_nxt  = st_r;
    q_pop   = 1'b0;
    oq_push = 1'b0;
    case (st_r)
      ST_IDLE: begin
        if (!q_empty && (!q_item.is_point || !oq_full)) begin
          q_pop  = 1'b1;
          st_nxt = q_item.is_point ? ST_DOT : ST_DIV;
        end
      end
      ST_DIV: begin
        if (cnt_r == CNT_W'(1)) st_nxt = ST_PREP;
      end
      ST_PREP: st_nxt = ST_CORDIC;
      ST_CORDIC: begin
        if (cnt_r == CNT_W'(CORDIC_STEPS)) st_nxt = ST_DOT;
      end
      ST_DOT: begin
        if (ph_r == PH_FIN && last_dot) begin
          if (it_r.is_point) begin
            oq_push = 1'b1;
            st_nxt  = ST_IDLE;
          end else begin
            st_nxt = ST_COMMIT;
          end
        end
      end
      ST_COMMIT: st_nxt = ST_IDLE;
      default:   st_nxt = ST_IDLE;
    endcase
  end

  // angle scaling, CORDIC step
  always_comb begin
    mag   = q_item.angle[16] ? 17'(-q_item.angle) : 17'(q_item.angle);
    ba    = it_r.angle[16] ? (32'd0 - quo_r) : quo_r;
    flp   = ba[31] ^ ba[30];
    ba2   = {ba[31] ^ flp, ba[30:0]};
    kk    = cnt_r[4:0];
    dx    = cy_r >>> kk;
    dy    = cx_r >>> kk;
    atv   = signed'(CORDIC_W'(atan_at(kk)));
    fx    = flip_r ? -cx_r : cx_r;
    fy    = flip_r ? -cy_r : cy_r;
  end

  // twist rotation
  always_comb begin
    for (int i = 0; i < 9; i++) w[i] = (i % 4 == 0) ? ONE : 32'sd0;
    case (it_r.axis)
      AXIS_X: begin
        w[4] = c_r; w[5] = -s_r; w[7] = s_r; w[8] = c_r;
      end
      AXIS_Y: begin
        w[0] = c_r; w[2] = -s_r; w[6] = s_r; w[8] = c_r;
      end
      AXIS_Z: begin
        w[0] = c_r; w[1] = -s_r; w[3] = s_r; w[4] = c_r;
      end
      default: ;
    endcase
  end

  // operand selection for one product term
  always_comb begin
    j     = (ph_r < 3'd3) ? ph_r[1:0] : 2'd0;
    tix   = (ph_r == PH_FIN) ? r_r : j;
    ridx  = it_r.body ? (4'({r_r, 1'b0}) + 4'(r_r) + 4'(j))
                      : (4'({j, 1'b0}) + 4'(j) + 4'(k_r));
    widx  = it_r.body ? (4'({j, 1'b0}) + 4'(j) + 4'(k_r))
                      : (4'({r_r, 1'b0}) + 4'(r_r) + 4'(j));
    sidx  = 4'({r_r, 1'b0}) + 4'(r_r) + 4'(k_r);
    case (tix)
      2'd0:    vec_t = it_r.v0;
      2'd1:    vec_t = it_r.v1;
      default: vec_t = it_r.v2;
    endcase
    vec_j = vec_t;
    tr_t  = tr_r[tix];
    a_op  = it_r.body ? rot_r[ridx] : w[widx];
    if (k_r == 2'd3) b_op = it_r.body ? vec_j : tr_t;
    else b_op = it_r.body ? w[widx] : rot_r[ridx];
    if (k_r == 2'd3) add_v = it_r.body ? tr_t : vec_t;
    else add_v = 32'sd0;
    prod_nxt = a_op * b_op;
    rnd  = (acc_r + RND_HALF) >>> ROT_FRAC_BITS;
    rsum = SUM_W'(rnd) + SUM_W'(add_v);
    res  = sat32(rsum);
  end

  assign oq_data = '{x: ob_r[0], y: ob_r[1], z: res};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 9; i++) rot_r[i] <= (i % 4 == 0) ? ONE : 32'sd0;
      for (int i = 0; i < 3; i++) tr_r[i] <= 32'sd0;
    end else begin
      case (st_r)
        ST_IDLE: begin
          if (q_pop) begin
            it_r   <= q_item;
            mag_r  <= mag;
            frac_r <= 22'(mag) * 22'(ANG_REM) + 22'(ANG_RND);
            cnt_r  <= '0;
            r_r    <= 2'd0;
            k_r    <= q_item.is_point ? 2'd3 : 2'd0;
            ph_r   <= 3'd0;
          end
        end
        ST_DIV: begin
          // both products first, then their sum, taken mod one turn
          if (cnt_r == '0) begin
            base_r <= 34'(mag_r) * 34'(ANG_MUL);
            recp_r <= 45'(frac_r) * 45'(ANG_RECIP);
          end else begin
            quo_r <= 32'(base_r + 34'(recp_r >> ANG_RECIP_SH));
          end
          cnt_r <= cnt_r + 1'b1;
        end
        ST_PREP: begin
          cx_r   <= CORDIC_W'(CORDIC_GAIN);
          cy_r   <= '0;
          cz_r   <= CORDIC_W'(signed'(ba2));
          flip_r <= flp;
          cnt_r  <= '0;
        end
        ST_CORDIC: begin
          if (cnt_r == CNT_W'(CORDIC_STEPS)) begin
            c_r <= cordic_out(fx);
            s_r <= cordic_out(fy);
          end else begin
            if (!cz_r[CORDIC_W-1]) begin
              cx_r <= cx_r - dx;
              cy_r <= cy_r + dy;
              cz_r <= cz_r - atv;
            end else begin
              cx_r <= cx_r + dx;
              cy_r <= cy_r - dy;
              cz_r <= cz_r + atv;
            end
            cnt_r <= cnt_r + 1'b1;
          end
        end
        ST_DOT: begin
          prod_r <= prod_nxt;
          case (ph_r)
            3'd1:    acc_r <= ACC_W'(prod_r);
            3'd2,
            3'd3:    acc_r <= acc_r + ACC_W'(prod_r);
            default: ;
          endcase
          if (ph_r == PH_FIN) begin
            ph_r <= 3'd0;
            if (it_r.is_point) begin
              if (r_r != 2'd2) ob_r[r_r[0]] <= res;
              r_r <= r_r + 1'b1;
            end else begin
              if (k_r == 2'd3) ntr_r[r_r] <= res;
              else nrot_r[sidx] <= res;
              if (k_r == 2'd3) begin
                k_r <= 2'd0;
                r_r <= r_r + 1'b1;
              end else begin
                k_r <= k_r + 1'b1;
              end
            end
          end else begin
            ph_r <= ph_r + 1'b1;
          end
        end
        ST_COMMIT: begin
          for (int i = 0; i < 9; i++) rot_r[i] <= nrot_r[i];
          for (int i = 0; i < 3; i++) tr_r[i] <= ntr_r[i];
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/pcpt_outq.sv =====
// ----------------------------------------------------------------------------
// pcpt_outq
// Two-entry result queue between the engine and the result ports.
// ----------------------------------------------------------------------------
module pcpt_outq import pcpt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               oq_push,
  input  point_t             oq_data,
  output logic               oq_full,
  output logic               out_empty,
  input  logic               out_pop,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z
);

  point_t     mem_r [2];
  logic [1:0] cnt_r;
  logic       wp_r;
  logic       rp_r;
  logic       pop;

  assign oq_full   = (cnt_r == 2'd2);
  assign out_empty = (cnt_r == 2'd0);
  assign pop       = out_pop && !out_empty;
  assign out_x     = mem_r[rp_r].x;
  assign out_y     = mem_r[rp_r].y;
  assign out_z     = mem_r[rp_r].z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_r + 2'(oq_push) - 2'(pop);
      if (oq_push) wp_r <= !wp_r;
      if (pop) rp_r <= !rp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (oq_push) mem_r[wp_r] <= oq_data;
  end

endmodule

// ===== hw/rtl/pose_compose_point_transform.sv =====
// ----------------------------------------------------------------------------
// pose_compose_point_transform
// Rigid pose accumulator with point transform.
//
// Requests enter through a queue-style port (in_push / in_full). A compose
// request premultiplies (fixed frame) or postmultiplies (body frame) the pose
// by a twist about x, y or z and gives no result. A point request gives
// rotation * point + translation on out_x/y/z, read with out_pop while
// out_empty is low. Op code three is taken and dropped.
// A two-entry input queue decouples the port from the engine, which runs one
// request at a time and forms its dot products on a single shared 32x32
// multiplier. A point holds the engine for a pick-up and three dot products;
// its result goes to the result queue as the third dot product completes.
// A compose holds it for pick-up, the angle scaling, set-up, the CORDIC
// steps and their output, twelve dot products and a commit of the pose.
// Reset loads the identity pose and empties both queues. A stalled reader
// fills the two-entry result queue; the engine then holds further points and
// the input queue fills, raising in_full.
// ----------------------------------------------------------------------------
module pose_compose_point_transform import pcpt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [1:0]         in_op,
  input  logic [1:0]         in_axis,
  input  logic signed [16:0] in_angle,
  input  logic signed [31:0] in_shift_x,
  input  logic signed [31:0] in_shift_y,
  input  logic signed [31:0] in_shift_z,
  input  logic signed [31:0] in_point_x,
  input  logic signed [31:0] in_point_y,
  input  logic signed [31:0] in_point_z,
  output logic               out_empty,
  input  logic               out_pop,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z
);

  logic   q_empty;
  logic   q_pop;
  item_t  q_item;
  logic   oq_full;
  logic   oq_push;
  point_t oq_data;

  pcpt_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_op      (in_op),
    .in_axis    (in_axis),
    .in_angle   (in_angle),
    .in_shift_x (in_shift_x),
    .in_shift_y (in_shift_y),
    .in_shift_z (in_shift_z),
    .in_point_x (in_point_x),
    .in_point_y (in_point_y),
    .in_point_z (in_point_z),
    .q_pop      (q_pop),
    .q_empty    (q_empty),
    .q_item     (q_item)
  );

  pcpt_engine u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .oq_full (oq_full),
    .oq_push (oq_push),
    .oq_data (oq_data)
  );

  pcpt_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .oq_push   (oq_push),
    .oq_data   (oq_data),
    .oq_full   (oq_full),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_z     (out_z)
  );

  // engine never writes a result into a full queue
  a_no_oq_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    oq_push |-> !oq_full) else $error("result queue overflow");

  // engine only takes an item that is there
  a_no_q_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty) else $error("input queue underflow");

  // a result push never coincides with picking up a new request
  a_push_not_pop: assert property (@(posedge clk) disable iff (!rst_n)
    oq_push |-> !q_pop) else $error("engine pushed and popped together");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty) else $error("result queue not empty after reset");

endmodule
